// ===== rtl/core/alu8f_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8f_pkg: shared types for the 8-bit accumulator alu
// opcode encoding, flag layout and the result record
// ----------------------------------------------------------------------------
`default_nettype none

package alu8f_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_SUB     = 5'd2,
    OP_SBC     = 5'd3,
    OP_AND     = 5'd4,
    OP_XOR     = 5'd5,
    OP_OR      = 5'd6,
    OP_CP      = 5'd7,
    OP_INC     = 5'd8,
    OP_DEC     = 5'd9,
    OP_INC_ACC = 5'd10,
    OP_DEC_ACC = 5'd11,
    OP_ADD16   = 5'd12,
    OP_ADD_SP  = 5'd13,
    OP_DAA     = 5'd14,
    OP_SCF     = 5'd15,
    OP_CPL     = 5'd16,
    OP_CCF     = 5'd17,
    OP_LOAD    = 5'd18
  } op_t;

  // bit3 z, bit2 n, bit1 h, bit0 c
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  accumulator;
    flags_t      flags;
  } result_t;

  localparam logic [3:0] NIBBLE_MAX = 4'hF;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
  localparam logic [7:0] BCD_BYTE_MAX = 8'h99;
  localparam logic [7:0] DAA_LOW_ADJ = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;

endpackage

`default_nettype wire

// ===== rtl/core/cpu_alu_8bit_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags: 8-bit accumulator alu with z/n/h/c flags
// one instruction per transaction; keeps the accumulator and the flag register
// ----------------------------------------------------------------------------
// an accepted instruction's result is registered in the result register or the skid register
// throughput: 1 instruction per cycle while item_stall is low; the accumulator/flag
//   feedback through the combinational alu datapath is the only loop
// a two-entry output (result register plus skid register) keeps input flowing
//   for one more instruction while the result side stalls
// reset: synchronous, active high; clears the accumulator, flags and valids
`default_nettype none

module cpu_alu_8bit_with_flags
  import alu8f_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [4:0]  op,
  input  wire logic [7:0]  operand,
  input  wire logic [15:0] wide_left,
  input  wire logic [15:0] wide_right,
  input  wire logic [3:0]  flags_load,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      value,
  output logic [7:0]       accumulator,
  output logic [3:0]       flags
);

  // architectural state
  logic [7:0] acc_reg;
  flags_t     flag_reg;

  // output register and skid register
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic    accept;
  logic    load_out;

  // alu datapath
  logic [7:0]  acc_next;
  flags_t      flag_next;
  logic [15:0] value_next;
  logic        use_acc;

  logic        cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;
  logic [7:0]  step_src;
  logic [7:0]  inc_res;
  logic [7:0]  dec_res;
  logic [16:0] wide_sum;
  logic [12:0] wide_low;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_byte;
  logic [7:0]  daa_adj;
  logic        daa_carry;
  logic [7:0]  daa_res;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign load_out   = !out_valid || !result_stall;

  always_comb begin
    // carry in only for adc / sbc
    cin = ((op_t'(op) == OP_ADC) || (op_t'(op) == OP_SBC)) ? flag_reg.c : 1'b0;

    add_sum  = {1'b0, acc_reg} + {1'b0, operand} + {8'd0, cin};
    add_nib  = {1'b0, acc_reg[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
    // top bit of the wrapped difference is the borrow
    sub_diff = {1'b0, acc_reg} - {1'b0, operand} - {8'd0, cin};
    sub_nib  = {1'b0, acc_reg[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};

    // inc/dec work on the operand byte or the accumulator
    step_src = ((op_t'(op) == OP_INC) || (op_t'(op) == OP_DEC)) ? operand : acc_reg;
    inc_res  = step_src + 8'd1;
    dec_res  = step_src - 8'd1;

    wide_sum = {1'b0, wide_left} + {1'b0, wide_right};
    wide_low = {1'b0, wide_left[11:0]} + {1'b0, wide_right[11:0]};

    // stack pointer plus sign-extended offset; flags from the unsigned low byte
    sp_sum  = wide_left + {{8{operand[7]}}, operand};
    sp_nib  = {1'b0, wide_left[3:0]} + {1'b0, operand[3:0]};
    sp_byte = {1'b0, wide_left[7:0]} + {1'b0, operand};

    // decimal adjust
    daa_adj   = 8'd0;
    daa_carry = flag_reg.c;
    if (flag_reg.n) begin
      if (flag_reg.h) daa_adj = daa_adj | DAA_LOW_ADJ;
      if (flag_reg.c) daa_adj = daa_adj | DAA_HIGH_ADJ;
      daa_res = acc_reg - daa_adj;
    end else begin
      if (flag_reg.h || (acc_reg[3:0] > BCD_DIGIT_MAX)) daa_adj = daa_adj | DAA_LOW_ADJ;
      if (flag_reg.c || (acc_reg > BCD_BYTE_MAX)) begin
        daa_adj   = daa_adj | DAA_HIGH_ADJ;
        daa_carry = 1'b1;
      end
      daa_res = acc_reg + daa_adj;
    end
  end

  always_comb begin
    acc_next   = acc_reg;
    flag_next  = flag_reg;
    value_next = 16'd0;
    use_acc    = 1'b1;
    unique case (op_t'(op))
      OP_ADD, OP_ADC: begin
        acc_next  = add_sum[7:0];
        flag_next = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_nib[4], c: add_sum[8]};
      end
      OP_SUB, OP_SBC: begin
        acc_next  = sub_diff[7:0];
        flag_next = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_nib[4], c: sub_diff[8]};
      end
      OP_CP: begin
        flag_next = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_nib[4], c: sub_diff[8]};
      end
      OP_AND: begin
        acc_next  = acc_reg & operand;
        flag_next = '{z: ((acc_reg & operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        acc_next  = acc_reg ^ operand;
        flag_next = '{z: ((acc_reg ^ operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        acc_next  = acc_reg | operand;
        flag_next = '{z: ((acc_reg | operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        flag_next  = '{z: (inc_res == 8'd0), n: 1'b0, h: (step_src[3:0] == NIBBLE_MAX),
                       c: flag_reg.c};
        value_next = {8'd0, inc_res};
        use_acc    = 1'b0;
      end
      OP_DEC: begin
        flag_next  = '{z: (dec_res == 8'd0), n: 1'b1, h: (step_src[3:0] == 4'd0),
                       c: flag_reg.c};
        value_next = {8'd0, dec_res};
        use_acc    = 1'b0;
      end
      OP_INC_ACC: begin
        acc_next  = inc_res;
        flag_next = '{z: (inc_res == 8'd0), n: 1'b0, h: (step_src[3:0] == NIBBLE_MAX),
                      c: flag_reg.c};
      end
      OP_DEC_ACC: begin
        acc_next  = dec_res;
        flag_next = '{z: (dec_res == 8'd0), n: 1'b1, h: (step_src[3:0] == 4'd0),
                      c: flag_reg.c};
      end
      OP_ADD16: begin
        flag_next  = '{z: flag_reg.z, n: 1'b0, h: wide_low[12], c: wide_sum[16]};
        value_next = wide_sum[15:0];
        use_acc    = 1'b0;
      end
      OP_ADD_SP: begin
        flag_next  = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_byte[8]};
        value_next = sp_sum;
        use_acc    = 1'b0;
      end
      OP_DAA: begin
        acc_next  = daa_res;
        flag_next = '{z: (daa_res == 8'd0), n: flag_reg.n, h: 1'b0, c: daa_carry};
      end
      OP_SCF: begin
        flag_next = '{z: flag_reg.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CPL: begin
        acc_next  = ~acc_reg;
        flag_next = '{z: flag_reg.z, n: 1'b1, h: 1'b1, c: flag_reg.c};
      end
      OP_CCF: begin
        flag_next = '{z: flag_reg.z, n: 1'b0, h: 1'b0, c: !flag_reg.c};
      end
      OP_LOAD: begin
        acc_next  = operand;
        flag_next = flags_t'(flags_load);
      end
      default: begin
        // unused opcodes leave the state alone
      end
    endcase
    if (use_acc) value_next = {8'd0, acc_next};
  end

  // architectural state updates on every accepted item transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_reg  <= 8'd0;
      flag_reg <= '0;
    end else if (accept) begin
      acc_reg  <= acc_next;
      flag_reg <= flag_next;
    end
  end

  // result register with skid: a stalled result parks the next one in the skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= '{value: value_next, accumulator: acc_next, flags: flag_next};
      end
    end else if (accept) begin
      skid_data <= '{value: value_next, accumulator: acc_next, flags: flag_next};
    end
  end

  assign result_valid = out_valid;
  assign value        = out_data.value;
  assign accumulator  = out_data.accumulator;
  assign flags        = out_data.flags;

endmodule

`default_nettype wire
